// File: hdl/tqlu_pkg.sv
package tqlu_pkg;

    localparam int OBS_W    = 3;
    localparam int ACT_W    = 2;
    localparam int VAL_W    = 32;
    localparam int COEF_W   = 16;
    localparam int FRAC_W   = 16;

    localparam logic [COEF_W-1:0] GAMMA_RESET = 16'd62259;
    localparam logic [COEF_W-1:0] ALPHA_RESET = 16'd55706;

    localparam logic CFG_GAMMA = 1'b0;
    localparam logic CFG_ALPHA = 1'b1;

    typedef enum logic [1:0] {
        REQ_WRITE  = 2'd0,
        REQ_UPDATE = 2'd1,
        REQ_QUERY  = 2'd2
    } t_req;

    typedef logic [3:0] t_pc;

    localparam t_pc PC_IDLE     = 4'd0;
    localparam t_pc PC_SCAN     = 4'd1;
    localparam t_pc PC_SCAN_END = 4'd2;
    localparam t_pc PC_CUR      = 4'd3;
    localparam t_pc PC_TGT      = 4'd4;
    localparam t_pc PC_MULA     = 4'd5;
    localparam t_pc PC_NEW      = 4'd6;
    localparam t_pc PC_EMIT     = 4'd7;
    localparam t_pc PC_WRITE    = 4'd8;
    localparam t_pc PC_ZERO     = 4'd9;
    localparam t_pc PC_MAX      = 4'd10;

    typedef enum logic [2:0] {
        C_NEXT,
        C_JUMP,
        C_START,
        C_SCAN,
        C_QUERY,
        C_EMIT
    } t_cond;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_SCAN,
        RD_CUR
    } t_rd;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_NEW,
        WR_VAL
    } t_wr;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_MAX,
        RES_NEW,
        RES_WV,
        RES_ZERO
    } t_res;

    typedef struct packed {
        t_cond cond;
        t_pc   target;
        t_rd   rd;
        logic  mul_g;
        logic  tgt;
        logic  mul_a;
        t_wr   wr;
        t_res  res;
    } t_ctrl;

    // microprogram
    function automatic t_ctrl ucode(input t_pc pc);
        t_ctrl c;
        c = '{cond: C_NEXT, target: PC_IDLE, rd: RD_NONE, mul_g: 1'b0, tgt: 1'b0,
              mul_a: 1'b0, wr: WR_NONE, res: RES_NONE};
        unique case (pc)
            PC_IDLE: begin
                c.cond = C_START;
            end
            PC_SCAN: begin
                c.cond   = C_SCAN;
                c.rd     = RD_SCAN;
            end
            PC_SCAN_END: begin
                c.cond   = C_QUERY;
                c.target = PC_MAX;
            end
            PC_CUR: begin
                c.rd     = RD_CUR;
                c.mul_g  = 1'b1;
            end
            PC_TGT: begin
                c.tgt    = 1'b1;
            end
            PC_MULA: begin
                c.mul_a  = 1'b1;
            end
            PC_NEW: begin
                c.wr     = WR_NEW;
                c.res    = RES_NEW;
            end
            PC_EMIT: begin
                c.cond   = C_EMIT;
                c.target = PC_IDLE;
            end
            PC_WRITE: begin
                c.cond   = C_JUMP;
                c.target = PC_EMIT;
                c.wr     = WR_VAL;
                c.res    = RES_WV;
            end
            PC_ZERO: begin
                c.cond   = C_JUMP;
                c.target = PC_EMIT;
                c.res    = RES_ZERO;
            end
            PC_MAX: begin
                c.cond   = C_JUMP;
                c.target = PC_EMIT;
                c.res    = RES_MAX;
            end
            default: begin
                c.cond   = C_JUMP;
                c.target = PC_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

// File: hdl/tqlu_ram.sv
module tqlu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// File: hdl/tabular_q_learning_update_unit.sv
// Tabular Q-learning update unit.
// Input stream (s_axis): one request item; tuser is the request kind (write,
// update, query), tlast marks a final step. Output stream (m_axis): exactly one
// result item per request: greedy action, Q16.16 value, saturation flag in tuser.
// Config port: gamma (index 0) and alpha (index 1), Q0.16. The user must write
// them only while idle; the block itself does not enforce this. A microcoded
// sequencer walks the table through one RAM read per cycle and, for an update,
// then runs two multiplies and one write-back. A write, an invalid or an unused
// request goes through its result step to the emit step; a query scans the row
// and emits its maximum; an update scans the next row (skipped on a final step),
// reads the current value, forms the target, multiplies and writes back, then
// emits.
// The next item is accepted the cycle after the result is loaded into the
// output register. If the receiver stalls, the finished result waits in the
// sequencer's emit step and the output register holds; s_axis_tready stays low.
// Reset (synchronous, active low) returns to idle, clears the output valid and
// restores gamma = 0.95, alpha = 0.85. Table contents are undefined until written.
module tabular_q_learning_update_unit #(
    parameter int NUM_OBS     = 8,
    parameter int NUM_ACTIONS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // obs_index, action_taken, reward, next_obs, write_value
    input  logic [1:0]  s_axis_tuser,   // req_type
    input  logic        s_axis_tlast,   // final_step
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // greedy_action, q_value, zero pad
    output logic        m_axis_tuser,   // saturated
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);
    import tqlu_pkg::*;

    localparam int DEPTH = NUM_OBS * NUM_ACTIONS;
    localparam int AW    = $clog2(DEPTH);
    localparam int ACW   = $clog2(NUM_ACTIONS);

    t_pc               r_pc, n_pc;
    t_ctrl             w_ctrl;
    logic              r_out_valid;
    logic [COEF_W-1:0] r_gamma, r_alpha;

    t_req              r_req;
    logic [OBS_W-1:0]  r_obs, r_scan_row;
    logic [ACT_W-1:0]  r_act;
    logic [VAL_W-1:0]  r_reward, r_wv;
    logic              r_fin;
    logic [ACW-1:0]    r_col, r_rd_col;
    logic              r_rd_scan_d;
    logic [VAL_W-1:0]  r_best, r_cur;
    logic [ACW-1:0]    r_best_act;
    logic [48:0]       r_p1;
    logic [33:0]       r_diff;
    logic [50:0]       r_p2;
    logic [ACW-1:0]    r_res_act;
    logic [VAL_W-1:0]  r_res_q;
    logic              r_res_sat;
    logic [ACT_W-1:0]  r_o_act;
    logic [VAL_W-1:0]  r_o_q;
    logic              r_o_sat;

    logic              w_in_acc, w_slot_free, w_emit, w_col_last;
    logic              w_vs, w_va, w_vn;
    t_pc               w_dispatch;
    t_req              w_req_in;
    logic [OBS_W-1:0]  w_obs_in, w_next_in;
    logic [ACT_W-1:0]  w_act_in;
    logic [AW-1:0]     w_scan_addr, w_cur_addr, w_raddr;
    logic              w_re, w_we;
    logic [VAL_W-1:0]  w_wdata, w_rdata;
    logic [32:0]       w_target;
    logic [35:0]       w_new;
    logic              w_sat_hi, w_sat_lo;
    logic [VAL_W-1:0]  w_new_clamp;

    assign w_ctrl    = ucode(r_pc);
    assign w_req_in  = t_req'(s_axis_tuser);
    assign w_obs_in  = s_axis_tdata[2:0];
    assign w_act_in  = s_axis_tdata[4:3];
    assign w_next_in = s_axis_tdata[39:37];

    assign s_axis_tready = (w_ctrl.cond == C_START);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_slot_free   = !r_out_valid || m_axis_tready;
    assign w_emit        = (w_ctrl.cond == C_EMIT) && w_slot_free;
    assign w_col_last    = (r_col == ACW'(NUM_ACTIONS - 1));

    assign w_vs = 32'(w_obs_in)  < 32'(NUM_OBS);
    assign w_va = 32'(w_act_in)  < 32'(NUM_ACTIONS);
    assign w_vn = 32'(w_next_in) < 32'(NUM_OBS);

    always_comb begin
        unique case (w_req_in)
            REQ_WRITE:  w_dispatch = (w_vs && w_va) ? PC_WRITE : PC_ZERO;
            REQ_UPDATE: w_dispatch = (w_vs && w_va && (s_axis_tlast || w_vn)) ?
                                     (s_axis_tlast ? PC_CUR : PC_SCAN) : PC_ZERO;
            REQ_QUERY:  w_dispatch = w_vs ? PC_SCAN : PC_ZERO;
            default:    w_dispatch = PC_ZERO;
        endcase
    end

    always_comb begin
        n_pc = r_pc;
        unique case (w_ctrl.cond)
            C_NEXT:  n_pc = t_pc'(r_pc + 1'b1);
            C_JUMP:  n_pc = w_ctrl.target;
            C_START: if (w_in_acc) n_pc = w_dispatch;
            C_SCAN:  if (w_col_last) n_pc = t_pc'(r_pc + 1'b1);
            C_QUERY: n_pc = (r_req == REQ_QUERY) ? w_ctrl.target : t_pc'(r_pc + 1'b1);
            C_EMIT:  if (w_slot_free) n_pc = w_ctrl.target;
            default: n_pc = PC_IDLE;
        endcase
    end

    // table access
    assign w_scan_addr = AW'(32'(r_scan_row) * 32'(NUM_ACTIONS) + 32'(r_col));
    assign w_cur_addr  = AW'(32'(r_obs) * 32'(NUM_ACTIONS) + 32'(r_act));
    assign w_re        = (w_ctrl.rd != RD_NONE);
    assign w_raddr     = (w_ctrl.rd == RD_SCAN) ? w_scan_addr : w_cur_addr;
    assign w_we        = (w_ctrl.wr != WR_NONE);
    assign w_wdata     = (w_ctrl.wr == WR_NEW) ? w_new_clamp : r_wv;

    tqlu_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_cur_addr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // arithmetic
    assign w_target = r_fin ? {r_reward[31], r_reward}
                            : {r_reward[31], r_reward} + {r_p1[47], r_p1[47:16]};
    assign w_new    = {{4{r_cur[31]}}, r_cur} + {r_p2[50], r_p2[50:16]};
    assign w_sat_hi = !w_new[35] && (|w_new[34:31]);
    assign w_sat_lo =  w_new[35] && !(&w_new[34:31]);
    assign w_new_clamp = w_sat_hi ? 32'h7FFF_FFFF :
                         w_sat_lo ? 32'h8000_0000 : w_new[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_IDLE;
            r_out_valid <= 1'b0;
            r_rd_scan_d <= 1'b0;
            r_gamma     <= GAMMA_RESET;
            r_alpha     <= ALPHA_RESET;
        end else begin
            r_pc        <= n_pc;
            r_rd_scan_d <= (w_ctrl.rd == RD_SCAN);
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en && i_cfg_index == CFG_GAMMA) begin
                r_gamma <= i_cfg_wdata;
            end
            if (i_cfg_wr_en && i_cfg_index == CFG_ALPHA) begin
                r_alpha <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_req      <= w_req_in;
            r_obs      <= w_obs_in;
            r_act      <= w_act_in;
            r_reward   <= s_axis_tdata[36:5];
            r_wv       <= s_axis_tdata[71:40];
            r_fin      <= s_axis_tlast;
            r_scan_row <= (w_req_in == REQ_QUERY) ? w_obs_in : w_next_in;
            r_col      <= '0;
            r_best_act <= '0;
        end else if (w_ctrl.rd == RD_SCAN) begin
            r_col <= ACW'(r_col + 1'b1);
        end
        r_rd_col <= r_col;
        // first maximum wins on ties
        if (r_rd_scan_d && (r_rd_col == '0 || $signed(w_rdata) > $signed(r_best))) begin
            r_best     <= w_rdata;
            r_best_act <= r_rd_col;
        end
        if (w_ctrl.mul_g) begin
            r_p1 <= $signed({1'b0, r_gamma}) * $signed(r_best);
        end
        if (w_ctrl.tgt) begin
            r_cur  <= w_rdata;
            r_diff <= {w_target[32], w_target} - {{2{w_rdata[31]}}, w_rdata};
        end
        if (w_ctrl.mul_a) begin
            r_p2 <= $signed({1'b0, r_alpha}) * $signed(r_diff);
        end
        case (w_ctrl.res)
            RES_MAX: begin
                r_res_act <= r_best_act;
                r_res_q   <= r_best;
                r_res_sat <= 1'b0;
            end
            RES_NEW: begin
                r_res_act <= r_best_act;
                r_res_q   <= w_new_clamp;
                r_res_sat <= w_sat_hi || w_sat_lo;
            end
            RES_WV: begin
                r_res_act <= '0;
                r_res_q   <= r_wv;
                r_res_sat <= 1'b0;
            end
            RES_ZERO: begin
                r_res_act <= '0;
                r_res_q   <= '0;
                r_res_sat <= 1'b0;
            end
            default: begin
            end
        endcase
        if (w_emit) begin
            r_o_act <= ACT_W'(r_res_act);
            r_o_q   <= r_res_q;
            r_o_sat <= r_res_sat;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_o_q, r_o_act};
    assign m_axis_tuser  = r_o_sat;

`ifndef SYNTHESIS
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_we)
        else $error("table written while idle");

    a_sat_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            (m_axis_tdata[33:2] == 32'h7FFF_FFFF || m_axis_tdata[33:2] == 32'h8000_0000))
        else $error("saturated result not at a limit");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second item taken before result");
`endif

endmodule
